[rtl/beti_pkg.sv]
`timescale 1ns / 1ps
package beti_pkg;

   localparam int TempBinsDefault = 256;
   localparam int TotW            = 40;
   localparam int OutW            = 48;
   localparam int CfgAddrW        = 3;
   localparam int CfgDataW        = 32;
   localparam int ReqDataW        = 128;
   localparam int RspDataW        = 48;

   localparam logic [31:0] Log10Of2Q32 = 32'd1292913986;
   localparam logic [TotW-1:0] TotMax = {TotW{1'b1}};
   localparam logic [OutW-1:0] OutMax = {OutW{1'b1}};

   // Register indexes of the configuration port.
   typedef enum logic [CfgAddrW-1:0] {
      CSR_LOG_TEMP_MIN  = 3'd0,
      CSR_LOG_TEMP_MAX  = 3'd1,
      CSR_INV_BIN_WIDTH = 3'd2,
      CSR_BAND_LOW      = 3'd3,
      CSR_BAND_HIGH     = 3'd4,
      CSR_DENSITY_SCALE = 3'd5,
      CSR_RESULT_SHIFT  = 3'd6,
      CSR_EMIS_FLOOR    = 3'd7
   } csr_index_type;

   typedef enum logic {
      OP_ACCUM = 1'b0,
      OP_CELL  = 1'b1
   } opcode_type;

   // Back-end sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LOG,
      ST_SCALE,
      ST_POS,
      ST_RD0,
      ST_RD1,
      ST_INTERP,
      ST_MUL,
      ST_SHIFT,
      ST_OUT,
      ST_ACC_RD,
      ST_ACC_WR
   } back_state_type;

   // Classified item passed from the front end to the back end.
   typedef struct packed {
      opcode_type  op;
      logic [7:0]  bin;
      logic [31:0] value;
      logic [31:0] density;
   } work_item_type;

   // Configuration snapshot.
   typedef struct packed {
      logic [24:0] log_temp_min;
      logic [24:0] log_temp_max;
      logic [23:0] inv_bin_width;
      logic [23:0] band_low_kev;
      logic [23:0] band_high_kev;
      logic [31:0] density_scale;
      logic [5:0]  result_shift;
      logic [31:0] emissivity_floor;
   } csr_type;

endpackage

[rtl/band_emissivity_table_interp_unit.sv]
`timescale 1ns / 1ps
// Channel | Direction | Beat contents
// req     | in        | tdata: temp_bin[7:0] energy_kev[31:8] bin_emissivity[63:32]
//         |           |        temperature_kelvin[95:64] cell_density[127:96]; tuser: opcode
// rsp     | out       | tdata: emissivity[47:0]
// csr     | in        | write enable, index, 32-bit data
// A cell beat is popped, then the log squaring unit runs, then come scaling, bin search
// and the two table reads, then the three multiplies done one 32-bit limb at a time,
// and last the result is saturated and presented.
// An accumulate beat is a table read-modify-write.
// After reset all TempBins table entries are cleared before beats are processed.
// Reset is synchronous and active high. A two-entry queue lets req beats land
// while the back end works; a waiting result holds only the next cell at its last step.
module band_emissivity_table_interp_unit
   import beti_pkg::*;
#(
   parameter int TempBins = TempBinsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,  // temp_bin, energy_kev, bin_emissivity,
                                           // temperature_kelvin, cell_density
   input  logic                req_tuser,  // opcode
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,  // emissivity
   input  logic                csr_wr_en,
   input  logic [CfgAddrW-1:0] csr_index,
   input  logic [CfgDataW-1:0] csr_wdata
);

   csr_type       csr_ff;
   logic          q_valid, q_pop;
   work_item_type q_item;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.log_temp_min     <= 25'd0;
         csr_ff.log_temp_max     <= 25'h1FFFFFF;
         csr_ff.inv_bin_width    <= 24'd65536;
         csr_ff.band_low_kev     <= 24'd0;
         csr_ff.band_high_kev    <= 24'hFFFFFF;
         csr_ff.density_scale    <= 32'd65536;
         csr_ff.result_shift     <= 6'd32;
         csr_ff.emissivity_floor <= 32'd1;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_LOG_TEMP_MIN:  csr_ff.log_temp_min     <= csr_wdata[24:0];
            CSR_LOG_TEMP_MAX:  csr_ff.log_temp_max     <= csr_wdata[24:0];
            CSR_INV_BIN_WIDTH: csr_ff.inv_bin_width    <= csr_wdata[23:0];
            CSR_BAND_LOW:      csr_ff.band_low_kev     <= csr_wdata[23:0];
            CSR_BAND_HIGH:     csr_ff.band_high_kev    <= csr_wdata[23:0];
            CSR_DENSITY_SCALE: csr_ff.density_scale    <= csr_wdata;
            CSR_RESULT_SHIFT:  csr_ff.result_shift     <= csr_wdata[5:0];
            CSR_EMIS_FLOOR:    csr_ff.emissivity_floor <= csr_wdata;
            default: ;
         endcase
      end
   end

   beti_front #(.TempBins(TempBins)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr       (csr_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item)
   );

   beti_back #(.TempBins(TempBins)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

[rtl/beti_ram.sv]
`timescale 1ns / 1ps
module beti_ram #(
   parameter int Width = 40,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/beti_front.sv]
`timescale 1ns / 1ps
module beti_front
   import beti_pkg::*;
#(
   parameter int TempBins = TempBinsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                req_tuser,
   input  csr_type             csr,
   output logic                q_valid,
   input  logic                q_pop,
   output work_item_type       q_item
);

   localparam int QDepth = 2;

   work_item_type slot_ff [QDepth];
   work_item_type slot_in;
   logic [1:0]    count_ff, count_in;
   logic          rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic          push, keep;
   logic [23:0]   energy;
   logic [7:0]    bin;

   assign req_tready = (count_ff != 2'd2);
   assign bin        = req_tdata[7:0];
   assign energy     = req_tdata[31:8];

   // Accumulate beats outside the band or past the table are dropped here.
   always_comb begin
      keep = 1'b1;
      if (req_tuser == OP_ACCUM) begin
         keep = (energy > csr.band_low_kev) && (energy < csr.band_high_kev)
                && ({24'd0, bin} < 32'(TempBins));
      end
      slot_in.op      = opcode_type'(req_tuser);
      slot_in.bin     = bin;
      slot_in.value   = (req_tuser == OP_ACCUM) ? req_tdata[63:32] : req_tdata[95:64];
      slot_in.density = req_tdata[127:96];
   end

   assign push      = req_tvalid && req_tready && keep;
   assign rd_ptr_in = rd_ptr_ff ^ q_pop;
   assign wr_ptr_in = wr_ptr_ff ^ push;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};

   // Queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   // Queue payload.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_item  = slot_ff[rd_ptr_ff];

endmodule

[rtl/beti_log.sv]
`timescale 1ns / 1ps
module beti_log
   import beti_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] temp,
   output logic        done,
   output logic [24:0] log2_q20
);

   logic [32:0] mant_ff, mant_in;
   logic [19:0] frac_ff, frac_in;
   logic [4:0]  exp_ff, exp_in;
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [65:0] sq;
   logic [31:0] t;
   logic [4:0]  lead;

   // Leading-one position of the temperature (zero taken as one).
   always_comb begin
      t    = (temp == 32'd0) ? 32'd1 : temp;
      lead = 5'd0;
      for (int k = 0; k < 32; k++) begin
         if (t[k]) begin
            lead = 5'(k);
         end
      end
   end

   assign sq = 66'(mant_ff) * 66'(mant_ff);

   // One squaring per cycle gives one fraction bit.
   always_comb begin
      mant_in = mant_ff;
      frac_in = frac_ff;
      exp_in  = exp_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         mant_in = {1'b0, t << (5'd31 - lead)};
         frac_in = 20'd0;
         exp_in  = lead;
         step_in = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sq[63]) begin
            mant_in = 33'(sq >> 32);
            frac_in = {frac_ff[18:0], 1'b1};
         end else begin
            mant_in = 33'(sq >> 31);
            frac_in = {frac_ff[18:0], 1'b0};
         end
         step_in = step_ff + 5'd1;
         busy_in = (step_ff != 5'd19);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      mant_ff <= mant_in;
      frac_ff <= frac_in;
      exp_ff  <= exp_in;
   end

   assign done     = busy_ff && (step_ff == 5'd19);
   assign log2_q20 = {exp_ff, frac_in};

endmodule

[rtl/beti_back.sv]
`timescale 1ns / 1ps
module beti_back
   import beti_pkg::*;
#(
   parameter int TempBins = TempBinsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  csr_type             csr,
   input  logic                q_valid,
   output logic                q_pop,
   input  work_item_type       q_item,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata
);

   localparam int AddrW = $clog2(TempBins);
   localparam logic [2:0] LastLimb = 3'd5;

   back_state_type state_ff, state_in;
   work_item_type  item_ff;
   logic [AddrW-1:0] clr_ff, clr_in;
   logic [AddrW-1:0] rd_addr, wr_addr, j_ff;
   logic [TotW-1:0]  rd_data, wr_data, lo_ff;
   logic             wr_en;
   logic             log_start, log_done;
   logic [24:0]      l2, t_ff, tc;
   logic [56:0]      lscale;
   logic [48:0]      pos_prod;
   logic [32:0]      pos;
   logic [20:0]      f_ff;
   logic [61:0]      interp;
   logic [191:0]     acc_ff, acc_in;
   logic [1:0]       mstep_ff, mstep_in;
   logic [2:0]       limb_ff, limb_in;
   logic [31:0]      carry_ff, carry_in;
   logic [31:0]      mfac, limb;
   logic [63:0]      limb_prod;
   logic [191:0]     shifted;
   logic [OutW-1:0]  res_ff, res_in, sat;
   logic             out_valid_ff;
   logic [40:0]      sum;

   beti_ram #(.Width(TotW), .Depth(TempBins)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // The log unit latches the temperature of the beat popped this cycle.
   beti_log u_log (
      .clock   (clock),
      .reset   (reset),
      .start   (log_start),
      .temp    (q_item.value),
      .done    (log_done),
      .log2_q20(l2)
   );

   assign lscale   = 57'(l2) * 57'(Log10Of2Q32);
   assign tc       = (t_ff > csr.log_temp_max) ? csr.log_temp_max : t_ff;
   assign pos_prod = 49'((tc > csr.log_temp_min) ? (tc - csr.log_temp_min) : 25'd0)
                     * 49'(csr.inv_bin_width);
   assign pos      = 33'(pos_prod >> 16);
   assign sum      = 41'(rd_data) + 41'(item_ff.value);
   assign interp   = 62'(lo_ff) * 62'(21'h100000 - f_ff) + 62'(rd_data) * 62'(f_ff);
   assign mfac     = (mstep_ff == 2'd2) ? csr.density_scale : item_ff.density;

   // The product is kept as six 32-bit limbs, one limb multiplied per cycle.
   assign limb      = acc_ff[{limb_ff, 5'd0} +: 32];
   assign limb_prod = 64'(limb) * 64'(mfac) + 64'(carry_ff);
   assign shifted   = acc_ff >> csr.result_shift;
   assign sat       = (shifted[191:OutW] != '0) ? OutMax : shifted[OutW-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_ff == AddrW'(TempBins - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (q_valid) begin
               state_in = (q_item.op == OP_CELL) ? ST_LOG : ST_ACC_RD;
            end
         end
         ST_LOG:    if (log_done) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_POS;
         ST_POS:    state_in = ST_RD0;
         ST_RD0:    state_in = ST_RD1;
         ST_RD1:    state_in = ST_INTERP;
         ST_INTERP: state_in = ST_MUL;
         ST_MUL:    if (mstep_ff == 2'd2 && limb_ff == LastLimb) state_in = ST_SHIFT;
         ST_SHIFT:  if (!out_valid_ff) state_in = ST_OUT;
         ST_OUT:    state_in = ST_IDLE;
         ST_ACC_RD: state_in = ST_ACC_WR;
         ST_ACC_WR: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath controls.
   always_comb begin
      q_pop     = (state_ff == ST_IDLE) && q_valid;
      log_start = (state_ff == ST_IDLE) && q_valid && (q_item.op == OP_CELL);
      clr_in    = clr_ff + AddrW'(1);
      wr_en     = 1'b0;
      wr_addr   = AddrW'(item_ff.bin);
      wr_data   = (sum > 41'(TotMax)) ? TotMax : sum[TotW-1:0];
      rd_addr   = AddrW'(item_ff.bin);
      mstep_in  = 2'd0;
      limb_in   = 3'd0;
      carry_in  = 32'd0;
      acc_in    = acc_ff;
      res_in    = res_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         ST_ACC_WR: wr_en = 1'b1;
         ST_RD0:    rd_addr = j_ff;
         ST_RD1:    rd_addr = j_ff + AddrW'(1);
         ST_INTERP: acc_in = 192'(interp >> 20);
         ST_MUL: begin
            acc_in[{limb_ff, 5'd0} +: 32] = limb_prod[31:0];
            if (limb_ff == LastLimb) begin
               mstep_in = mstep_ff + 2'd1;
            end else begin
               mstep_in = mstep_ff;
               limb_in  = limb_ff + 3'd1;
               carry_in = limb_prod[63:32];
            end
         end
         ST_SHIFT: begin
            if (!out_valid_ff) begin
               res_in = (sat < 48'(csr.emissivity_floor)) ? 48'(csr.emissivity_floor) : sat;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
         mstep_ff     <= 2'd0;
         limb_ff      <= 3'd0;
         carry_ff     <= 32'd0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         mstep_ff <= mstep_in;
         limb_ff  <= limb_in;
         carry_ff <= carry_in;
         if (state_ff == ST_OUT) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (q_pop) item_ff <= q_item;
      if (state_ff == ST_SCALE) t_ff <= 25'(lscale >> 32);
      if (state_ff == ST_LOG) t_ff <= (t_ff < csr.log_temp_min) ? csr.log_temp_min : t_ff;
      if (state_ff == ST_POS) begin
         if (pos[32:20] >= 13'(TempBins - 1)) begin
            j_ff <= AddrW'(TempBins - 2);
            f_ff <= 21'h100000;
         end else begin
            j_ff <= pos[20 +: AddrW];
            f_ff <= {1'b0, pos[19:0]};
         end
      end
      if (state_ff == ST_RD1) lo_ff <= rd_data;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = res_ff;

endmodule

[rtl/beti_checker.sv]
`timescale 1ns / 1ps
module beti_checker
   import beti_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspDataW-1:0] rsp_tdata
);

   // A waiting result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // No result comes out of reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // req_tvalid, req_tready and rsp_tvalid are always known once out of reset.
   assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_tvalid, req_tready, rsp_tvalid}))
      else $error("handshake line unknown");

endmodule

bind band_emissivity_table_interp_unit beti_checker u_beti_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
